### rtl/core/mipd_pkg.sv
// Shared types and constants for the minimum image pair distance block.
package mipd_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int BOX_W           = 31;
  localparam int INV_W           = 48;
  localparam int INV_HALF        = 24;
  localparam int FRAC_BITS       = 56;
  localparam int SQ_W            = 64;
  localparam int FIFO_DEPTH      = 4;
  localparam int AXIS_LAT        = 8;
  localparam int SQRT_STAGES     = 32;
  localparam int DIST_W          = 32;
  localparam int APB_AW          = 6;
  localparam int APB_DW          = 64;

  localparam logic [BOX_W-1:0] BOX_RESET = 31'd65536;
  localparam logic [INV_W-1:0] INV_RESET = 48'h0100_0000_0000;

  typedef enum logic [2:0] {
    REG_BOX_X,
    REG_BOX_Y,
    REG_BOX_Z,
    REG_INV_X,
    REG_INV_Y,
    REG_INV_Z
  } reg_idx_e;

  typedef struct packed {
    logic [BOX_W-1:0] box_x;
    logic [BOX_W-1:0] box_y;
    logic [BOX_W-1:0] box_z;
    logic [INV_W-1:0] inv_x;
    logic [INV_W-1:0] inv_y;
    logic [INV_W-1:0] inv_z;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic full;
  } fifo_stat_t;

endpackage

### rtl/core/mipd_front.sv
// Front end: takes a pair beat, forms per-axis difference magnitudes, feeds the queue.
module mipd_front import mipd_pkg::*; #(
  parameter int CoordWidth = COORD_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [CoordWidth-1:0] first_x_i,
  input  logic signed [CoordWidth-1:0] first_y_i,
  input  logic signed [CoordWidth-1:0] first_z_i,
  input  logic signed [CoordWidth-1:0] second_x_i,
  input  logic signed [CoordWidth-1:0] second_y_i,
  input  logic signed [CoordWidth-1:0] second_z_i,
  input  logic                         last_pair_i,
  input  fifo_stat_t                   stat_i,
  output logic                         push_o,
  output logic [3*CoordWidth:0]        data_o
);

  localparam int DW = CoordWidth + 1;

  logic                  vld_q, vld_d;
  logic [3*CoordWidth:0] data_q;
  logic [DW-1:0]         dx, dy, dz, nx, ny, nz;
  logic [CoordWidth-1:0] mx, my, mz;
  logic                  accept;

  always_comb begin
    dx = {first_x_i[CoordWidth-1], first_x_i} - {second_x_i[CoordWidth-1], second_x_i};
    dy = {first_y_i[CoordWidth-1], first_y_i} - {second_y_i[CoordWidth-1], second_y_i};
    dz = {first_z_i[CoordWidth-1], first_z_i} - {second_z_i[CoordWidth-1], second_z_i};
    nx = ~dx + DW'(1);
    ny = ~dy + DW'(1);
    nz = ~dz + DW'(1);
    mx = dx[DW-1] ? nx[CoordWidth-1:0] : dx[CoordWidth-1:0];
    my = dy[DW-1] ? ny[CoordWidth-1:0] : dy[CoordWidth-1:0];
    mz = dz[DW-1] ? nz[CoordWidth-1:0] : dz[CoordWidth-1:0];
  end

  assign push_o     = vld_q && !stat_i.full;
  assign in_ready_o = !vld_q || !stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign data_o     = data_q;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= {last_pair_i, mz, my, mx};
    end
  end

endmodule

### rtl/core/mipd_fifo.sv
// Short queue between the front end and the distance pipeline.
module mipd_fifo import mipd_pkg::*; #(
  parameter int Width = 97,
  parameter int Depth = FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output fifo_stat_t       stat_o
);

  localparam int AW = $clog2(Depth);

  logic [Width-1:0] entry_q [Depth];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]      cnt_q, cnt_d;

  assign data_o       = entry_q[rd_q];
  assign stat_o.valid = cnt_q != '0;
  assign stat_o.full  = cnt_q == (AW+1)'(Depth);

  always_comb begin
    wr_d  = push_i ? wr_q + AW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + AW'(1) : rd_q;
    cnt_d = cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= data_i;
    end
  end

endmodule

### rtl/core/mipd_axis.sv
// One axis: fold the difference into the box and square it, eight stages.
module mipd_axis import mipd_pkg::*; #(
  parameter int CoordWidth = COORD_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [CoordWidth-1:0] mag_i,
  input  logic [BOX_W-1:0]      box_i,
  input  logic [INV_W-1:0]      inv_i,
  output logic [SQ_W-1:0]       sq_o,
  output logic                  ovf_o
);

  localparam int DW  = CoordWidth;
  localparam int ML  = (DW + 1) / 2;
  localparam int MH  = DW - ML;
  localparam int PLW = ML + INV_HALF;
  localparam int PHW = MH + INV_HALF;
  localparam int PW  = DW + INV_W;
  localparam int NW  = PW - FRAC_BITS;
  localparam int NRW = NW + 1;
  localparam int NL  = (NRW + 1) / 2;
  localparam int NH  = NRW - NL;
  localparam int QLW = NL + BOX_W;
  localparam int QHW = NH + BOX_W;
  localparam int NBW = NRW + BOX_W;
  localparam int NXW = (NBW > SQ_W + 1) ? NBW : SQ_W + 1;
  localparam logic [FRAC_BITS-1:0] Half = {1'b1, {(FRAC_BITS-1){1'b0}}};

  logic [DW-1:0]        mag_a_q, mag_b_q, mag_c_q, mag_d_q, mag_e_q, mag_f_q;
  logic [PLW-1:0]       p00_q, p01_q;
  logic [PHW-1:0]       p10_q, p11_q;
  logic [PW-1:0]        s0_q, s1_q, p_q;
  logic [NRW-1:0]       nr_q, nr_d;
  logic [QLW-1:0]       q0_q;
  logic [QHW-1:0]       q1_q;
  logic [NBW-1:0]       nb_q;
  logic [DIST_W-1:0]    r_q;
  logic                 ovf_f_q, ovf_g_q, ovf_d;
  logic [SQ_W-1:0]      sq_q;
  logic [NW-1:0]        n;
  logic [FRAC_BITS-1:0] rem;
  logic                 inc;
  logic [NXW-1:0]       nbx, magx, r;

  always_comb begin
    n    = p_q[PW-1:FRAC_BITS];
    rem  = p_q[FRAC_BITS-1:0];
    inc  = (rem > Half) || ((rem == Half) && n[0]);
    nr_d = NRW'(n) + NRW'(inc);
    nbx  = NXW'(nb_q);
    magx = NXW'(mag_f_q);
    r    = (magx >= nbx) ? magx - nbx : nbx - magx;
    ovf_d = (|nbx[NXW-1:SQ_W]) || (|r[NXW-1:DIST_W]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_a_q <= mag_i;
      p00_q   <= PLW'(mag_i[ML-1:0]) * PLW'(inv_i[INV_HALF-1:0]);
      p01_q   <= PLW'(mag_i[ML-1:0]) * PLW'(inv_i[INV_W-1:INV_HALF]);
      p10_q   <= PHW'(mag_i[DW-1:ML]) * PHW'(inv_i[INV_HALF-1:0]);
      p11_q   <= PHW'(mag_i[DW-1:ML]) * PHW'(inv_i[INV_W-1:INV_HALF]);
      mag_b_q <= mag_a_q;
      s0_q    <= PW'(p00_q) + (PW'(p01_q) << INV_HALF);
      s1_q    <= PW'(p10_q) + (PW'(p11_q) << INV_HALF);
      mag_c_q <= mag_b_q;
      p_q     <= s0_q + (s1_q << ML);
      mag_d_q <= mag_c_q;
      nr_q    <= nr_d;
      mag_e_q <= mag_d_q;
      q0_q    <= QLW'(nr_q[NL-1:0]) * QLW'(box_i);
      q1_q    <= QHW'(nr_q[NRW-1:NL]) * QHW'(box_i);
      mag_f_q <= mag_e_q;
      nb_q    <= NBW'(q0_q) + (NBW'(q1_q) << NL);
      r_q     <= r[DIST_W-1:0];
      ovf_f_q <= ovf_d;
      sq_q    <= SQ_W'(r_q) * SQ_W'(r_q);
      ovf_g_q <= ovf_f_q;
    end
  end

  assign sq_o  = sq_q;
  assign ovf_o = ovf_g_q;

endmodule

### rtl/core/mipd_isqrt.sv
// Integer square root of a 64-bit value, one result bit per stage.
module mipd_isqrt import mipd_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SQ_W-1:0]   x_i,
  input  logic              sat_i,
  output logic [DIST_W-1:0] res_o,
  output logic              sat_o
);

  logic [SQ_W-1:0] x_q   [SQRT_STAGES];
  logic [SQ_W-1:0] res_q [SQRT_STAGES];
  logic            sat_q [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stg
    localparam logic [SQ_W-1:0] Bit = SQ_W'(1) << (2 * (SQRT_STAGES - 1 - s));
    logic [SQ_W-1:0] xi, ri, t;
    logic            si;

    if (s == 0) begin : g_first
      assign xi = x_i;
      assign ri = '0;
      assign si = sat_i;
    end else begin : g_rest
      assign xi = x_q[s-1];
      assign ri = res_q[s-1];
      assign si = sat_q[s-1];
    end

    assign t = ri + Bit;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (xi >= t) begin
          x_q[s]   <= xi - t;
          res_q[s] <= (ri >> 1) + Bit;
        end else begin
          x_q[s]   <= xi;
          res_q[s] <= ri >> 1;
        end
        sat_q[s] <= si;
      end
    end
  end

  assign res_o = res_q[SQRT_STAGES-1][DIST_W-1:0];
  assign sat_o = sat_q[SQRT_STAGES-1];

endmodule

### rtl/core/mipd_back.sv
// Back end: three axis pipelines, sum of squares, square root, saturating output select.
module mipd_back import mipd_pkg::*; #(
  parameter int CoordWidth = COORD_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  fifo_stat_t            stat_i,
  input  logic [3*CoordWidth:0] data_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DIST_W-1:0]     distance_o,
  output logic                  last_result_o
);

  localparam int Lat = AXIS_LAT + 1 + SQRT_STAGES;

  logic [Lat-1:0]    vld_q, last_q;
  logic              en;
  logic [SQ_W-1:0]   sx, sy, sz, sum_q;
  logic              ox, oy, oz, sat_q, sat_d;
  logic [SQ_W+1:0]   sum_d;
  logic [DIST_W-1:0] root;
  logic              root_sat;

  assign en    = !vld_q[Lat-1] || out_ready_i;
  assign pop_o = stat_i.valid && en;

  mipd_axis #(.CoordWidth(CoordWidth)) u_axis_x (
    .clk_i, .en_i(en), .mag_i(data_i[CoordWidth-1:0]),
    .box_i(cfg_i.box_x), .inv_i(cfg_i.inv_x), .sq_o(sx), .ovf_o(ox)
  );

  mipd_axis #(.CoordWidth(CoordWidth)) u_axis_y (
    .clk_i, .en_i(en), .mag_i(data_i[2*CoordWidth-1:CoordWidth]),
    .box_i(cfg_i.box_y), .inv_i(cfg_i.inv_y), .sq_o(sy), .ovf_o(oy)
  );

  mipd_axis #(.CoordWidth(CoordWidth)) u_axis_z (
    .clk_i, .en_i(en), .mag_i(data_i[3*CoordWidth-1:2*CoordWidth]),
    .box_i(cfg_i.box_z), .inv_i(cfg_i.inv_z), .sq_o(sz), .ovf_o(oz)
  );

  always_comb begin
    sum_d = (SQ_W+2)'(sx) + (SQ_W+2)'(sy) + (SQ_W+2)'(sz);
    sat_d = ox || oy || oz || (|sum_d[SQ_W+1:SQ_W]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= sum_d[SQ_W-1:0];
      sat_q <= sat_d;
      last_q <= {last_q[Lat-2:0], data_i[3*CoordWidth]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], pop_o};
    end
  end

  mipd_isqrt u_isqrt (
    .clk_i, .en_i(en), .x_i(sum_q), .sat_i(sat_q), .res_o(root), .sat_o(root_sat)
  );

  assign out_valid_o   = vld_q[Lat-1];
  assign distance_o    = root_sat ? '1 : root;
  assign last_result_o = last_q[Lat-1];

endmodule

### rtl/core/min_image_pair_distance.sv
// Top level: minimum image distance of a point pair in an orthorhombic periodic box.
//
//   channel | signals                                   | direction
//   in      | in_valid_i/in_ready_o, first_*, second_*, last_pair_i | beat in
//   out     | out_valid_o/out_ready_i, distance_o, last_result_o    | beat out
//   cfg     | psel, penable, pwrite, paddr, pwdata, prdata, pready  | APB, 64-bit
//
// One beat per cycle sustained while out_ready_i stays high; each result passes through
// the front register, queue, eight-stage axis fold, sum and 32 root stages.
// The 4-entry queue lets the front keep taking beats while the result stalls, until it is full.
// Reset clears control and loads box 1.0 and reciprocal 1.0 on every axis.
module min_image_pair_distance import mipd_pkg::*; #(
  parameter int CoordWidth = COORD_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [CoordWidth-1:0] first_x_i,
  input  logic signed [CoordWidth-1:0] first_y_i,
  input  logic signed [CoordWidth-1:0] first_z_i,
  input  logic signed [CoordWidth-1:0] second_x_i,
  input  logic signed [CoordWidth-1:0] second_y_i,
  input  logic signed [CoordWidth-1:0] second_z_i,
  input  logic                         last_pair_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [DIST_W-1:0]            distance_o,
  output logic                         last_result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_AW-1:0]            paddr,
  input  logic [APB_DW-1:0]            pwdata,
  output logic [APB_DW-1:0]            prdata,
  output logic                         pready
);

  localparam int FW = 3 * CoordWidth + 1;

  cfg_t             cfg_q;
  fifo_stat_t       stat;
  logic             push, pop, wr_en;
  logic [FW-1:0]    f_data, q_data;
  reg_idx_e         idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[APB_AW-1:3]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.box_x <= BOX_RESET;
      cfg_q.box_y <= BOX_RESET;
      cfg_q.box_z <= BOX_RESET;
      cfg_q.inv_x <= INV_RESET;
      cfg_q.inv_y <= INV_RESET;
      cfg_q.inv_z <= INV_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_BOX_X: cfg_q.box_x <= pwdata[BOX_W-1:0];
        REG_BOX_Y: cfg_q.box_y <= pwdata[BOX_W-1:0];
        REG_BOX_Z: cfg_q.box_z <= pwdata[BOX_W-1:0];
        REG_INV_X: cfg_q.inv_x <= pwdata[INV_W-1:0];
        REG_INV_Y: cfg_q.inv_y <= pwdata[INV_W-1:0];
        REG_INV_Z: cfg_q.inv_z <= pwdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BOX_X: prdata = APB_DW'(cfg_q.box_x);
      REG_BOX_Y: prdata = APB_DW'(cfg_q.box_y);
      REG_BOX_Z: prdata = APB_DW'(cfg_q.box_z);
      REG_INV_X: prdata = APB_DW'(cfg_q.inv_x);
      REG_INV_Y: prdata = APB_DW'(cfg_q.inv_y);
      REG_INV_Z: prdata = APB_DW'(cfg_q.inv_z);
      default:   prdata = '0;
    endcase
  end

  mipd_front #(.CoordWidth(CoordWidth)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .first_x_i, .first_y_i, .first_z_i, .second_x_i, .second_y_i, .second_z_i,
    .last_pair_i, .stat_i(stat), .push_o(push), .data_o(f_data)
  );

  mipd_fifo #(.Width(FW), .Depth(FIFO_DEPTH)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(f_data), .pop_i(pop),
    .data_o(q_data), .stat_o(stat)
  );

  mipd_back #(.CoordWidth(CoordWidth)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .stat_i(stat), .data_i(q_data), .pop_o(pop),
    .out_valid_o, .out_ready_i, .distance_o, .last_result_o
  );

  a_full_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.full |-> stat.valid)
    else $error("queue full while empty");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> stat.full)
    else $error("input stalled with room in queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> stat.valid)
    else $error("pop from empty queue");

  a_box_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && idx == REG_BOX_X) |=> cfg_q.box_x == $past(pwdata[BOX_W-1:0]))
    else $error("box_x write lost");

endmodule

### sim/mipd_checker.sv
// Scoreboard for min_image_pair_distance: tracks config writes, predicts and checks results.
`timescale 1ns / 1ps
module mipd_checker import mipd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic signed [31:0]  first_x_i,
  input  logic signed [31:0]  first_y_i,
  input  logic signed [31:0]  first_z_i,
  input  logic signed [31:0]  second_x_i,
  input  logic signed [31:0]  second_y_i,
  input  logic signed [31:0]  second_z_i,
  input  logic                last_pair_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [DIST_W-1:0]   distance_i,
  input  logic                last_result_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [APB_AW-1:0]   paddr_i,
  input  logic [APB_DW-1:0]   pwdata_i,
  input  logic                pready_i,
  output int                  pending_o,
  output int                  errors_o
);

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              last;
  } dist_beat_t;

  cfg_t       box_cfg;
  dist_beat_t dist_q[$];

  assign pending_o = dist_q.size();

  // Folded square of one axis; returns 0 when it overflows Q32.32.
  function automatic bit fold_square(input logic signed [31:0] a, input logic signed [31:0] b,
                                     input logic [BOX_W-1:0] box, input logic [INV_W-1:0] inv,
                                     output logic [63:0] sq);
    logic [63:0]  d, mag, n, r;
    logic [127:0] q, p;
    d   = {{32{a[31]}}, a} - {{32{b[31]}}, b};
    mag = d[63] ? -d : d;
    q   = {64'd0, mag} * {80'd0, inv};
    n   = q[119:56];
    if (q[55:0] > {1'b1, 55'd0} || (q[55:0] == {1'b1, 55'd0} && n[0]))
      n = n + 64'd1;
    p = {64'd0, n} * {97'd0, box};
    sq = '0;
    if (p[127:64] != 0) return 0;
    r = (p[63:0] <= mag) ? mag - p[63:0] : p[63:0] - mag;
    if (r[63:32] != 0) return 0;
    sq = r * r;
    return 1;
  endfunction

  function automatic logic [31:0] root_floor(input logic [63:0] x);
    logic [63:0] res, t;
    res = '0;
    for (int i = 31; i >= 0; i--) begin
      t = res | (64'd1 << i);
      if (t * t <= x) res = t;
    end
    return res[31:0];
  endfunction

  function automatic logic [31:0] pair_distance(input logic signed [31:0] ax, ay, az, bx, by, bz);
    logic [63:0] sx, sy, sz;
    logic [65:0] total;
    bit          ok;
    ok = fold_square(ax, bx, box_cfg.box_x, box_cfg.inv_x, sx);
    ok = fold_square(ay, by, box_cfg.box_y, box_cfg.inv_y, sy) && ok;
    ok = fold_square(az, bz, box_cfg.box_z, box_cfg.inv_z, sz) && ok;
    total = {2'b0, sx} + {2'b0, sy} + {2'b0, sz};
    if (!ok || total[65:64] != 0) return '1;
    return root_floor(total[63:0]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dist_beat_t exp_beat;
    if (!rst_ni) begin
      box_cfg <= '{BOX_RESET, BOX_RESET, BOX_RESET, INV_RESET, INV_RESET, INV_RESET};
      dist_q.delete();
      errors_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i)
        dist_q.push_back('{pair_distance(first_x_i, first_y_i, first_z_i,
                                         second_x_i, second_y_i, second_z_i), last_pair_i});
      if (out_valid_i && out_ready_i) begin
        if (dist_q.size() == 0) begin
          if (errors_o < 10) $display("ERROR: unexpected result beat dist=%h", distance_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_beat = dist_q.pop_front();
          if (exp_beat.distance !== distance_i || exp_beat.last !== last_result_i) begin
            if (errors_o < 10)
              $display("ERROR: dist exp %h got %h, last exp %b got %b",
                       exp_beat.distance, distance_i, exp_beat.last, last_result_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[APB_AW-1:3])
          REG_BOX_X: box_cfg.box_x <= pwdata_i[BOX_W-1:0];
          REG_BOX_Y: box_cfg.box_y <= pwdata_i[BOX_W-1:0];
          REG_BOX_Z: box_cfg.box_z <= pwdata_i[BOX_W-1:0];
          REG_INV_X: box_cfg.inv_x <= pwdata_i[INV_W-1:0];
          REG_INV_Y: box_cfg.inv_y <= pwdata_i[INV_W-1:0];
          REG_INV_Z: box_cfg.inv_z <= pwdata_i[INV_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### sim/min_image_pair_distance_test.sv
// Testbench top for min_image_pair_distance: stimulus, config phases and verdict.
`timescale 1ns / 1ps
module min_image_pair_distance_test;
  import mipd_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN       = 60;
  localparam int UNUSED_REG  = 6;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, last_pair_i, out_valid_o, out_ready_i, last_result_o;
  logic signed [31:0] first_x_i, first_y_i, first_z_i, second_x_i, second_y_i, second_z_i;
  logic [DIST_W-1:0] distance_o;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;
  int pending, errors, cycles;
  int hold_req, hold_done;

  min_image_pair_distance DUT (.*);

  mipd_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .first_x_i, .first_y_i, .first_z_i, .second_x_i, .second_y_i, .second_z_i, .last_pair_i,
    .out_valid_i(out_valid_o), .out_ready_i, .distance_i(distance_o),
    .last_result_i(last_result_o), .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite),
    .paddr_i(paddr), .pwdata_i(pwdata), .pready_i(pready),
    .pending_o(pending), .errors_o(errors)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: short random stalls, rare long ones, one long hold on request
  initial begin
    int stall;
    stall = 0;
    hold_done = 0;
    out_ready_i = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        stall = 400;
      end
      if (stall > 0) begin
        out_ready_i <= 0;
        stall--;
      end else begin
        out_ready_i <= 1;
        if ($urandom_range(0, 49) == 0) stall = $urandom_range(10, 40);
        else if ($urandom_range(0, 3) == 0) stall = $urandom_range(1, 3);
      end
    end
  end

  task automatic reg_write(input int idx, input logic [63:0] val);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= APB_AW'(idx * 8);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // one beat; valid stays high across back-to-back beats
  task automatic send_pair(input logic signed [31:0] ax, ay, az, bx, by, bz, input logic lp);
    int gap;
    in_valid_i  <= 1;
    first_x_i   <= ax;
    first_y_i   <= ay;
    first_z_i   <= az;
    second_x_i  <= bx;
    second_y_i  <= by;
    second_z_i  <= bz;
    last_pair_i <= lp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    gap = 0;
    if ($urandom_range(0, 39) == 0) gap = $urandom_range(10, 50);
    else if ($urandom_range(0, 4) == 0) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] near(input logic [31:0] base);
    int span;
    span = 1 << $urandom_range(2, 20);
    return base + $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic random_pairs(input int count);
    logic [31:0] ax, ay, az;
    for (int i = 0; i < count; i++) begin
      ax = $urandom;
      ay = $urandom;
      az = $urandom;
      if (i == count / 2 && hold_req == 0) hold_req = 1;
      if ($urandom_range(0, 1))
        send_pair(ax, ay, az, $urandom, $urandom, $urandom, $urandom_range(0, 1));
      else
        send_pair(ax, ay, az, near(ax), near(ay), near(az), $urandom_range(0, 1));
    end
  endtask

  task automatic set_box(input logic [30:0] bx, by, bz, input logic [47:0] ix, iy, iz);
    reg_write(REG_BOX_X, bx);
    reg_write(REG_BOX_Y, by);
    reg_write(REG_BOX_Z, bz);
    reg_write(REG_INV_X, ix);
    reg_write(REG_INV_Y, iy);
    reg_write(REG_INV_Z, iz);
  endtask

  initial begin
    logic [31:0] mx, mn;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    cycles = 0;
    hold_req = 0;
    rst_ni = 0;
    in_valid_i = 0;
    {first_x_i, first_y_i, first_z_i, second_x_i, second_y_i, second_z_i} = '0;
    last_pair_i = 0;
    {psel, penable, pwrite} = '0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed under reset box: extremes and rounding ties
    send_pair(0, 0, 0, 0, 0, 0, 0);
    send_pair(mx, mx, mx, mn, mn, mn, 1);
    send_pair(mn, mn, mn, mx, mx, mx, 0);
    send_pair(32'sd32768, 32'sd98304, 32'sd163840, 0, 0, 0, 1);
    send_pair(0, 0, 0, 32'sd32768, 32'sd98304, 32'sd163840, 0);
    send_pair(32'sd1, -32'sd1, 32'sd65535, 0, 0, 0, 1);
    send_pair(-1, mx, mn, 0, -1, 1, 0);
    drain();

    // unfolded box, large differences, writes to unused registers
    set_box(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0, 0);
    reg_write(UNUSED_REG, '1);
    reg_write(UNUSED_REG + 1, '1);
    send_pair(mx, 0, 0, mn, 0, 0, 1);
    send_pair(32'sd65535 << 16, 0, 0, 0, 0, 0, 0);
    send_pair(32'sd1 << 28, 32'sd1 << 28, 32'sd1 << 28, 0, 0, 0, 1);
    send_pair(32'sd3 << 16, 32'sd4 << 16, 0, 0, 0, 0, 0);
    send_pair(0, 0, 0, 0, 0, 0, 1);
    drain();

    // box 1 ulp with the largest reciprocal, zero box, mixed axes
    set_box(1, 0, 31'd655360, 48'hFFFF_FFFF_FFFF, 48'h0100_0000_0000, 48'd109951162778);
    send_pair(mx, mn, 32'sd327680, mn, mx, 0, 0);
    send_pair(1, 1, 32'sd983040, 0, 0, 0, 1);
    drain();

    set_box(BOX_RESET, BOX_RESET, BOX_RESET, INV_RESET, INV_RESET, INV_RESET);
    random_pairs(400);
    drain();
    set_box(31'd655360, 31'd655360, 31'd655360,
            48'd109951162778, 48'd109951162778, 48'd109951162778);
    random_pairs(400);
    drain();
    set_box(31'h7FFF_FFFF, 1, 31'd131072, 0, 48'hFFFF_FFFF_FFFF, 48'h0080_0000_0000);
    random_pairs(350);
    drain();
    for (int ph = 0; ph < 2; ph++) begin
      set_box(31'($urandom_range(1, 31'h7FFF_FFFF)), 31'($urandom_range(1, 1 << 24)),
              31'($urandom_range(1, 1 << 20)), 48'({$urandom, $urandom} & 48'hFFFF_FFFF_FFFF),
              48'({$urandom, $urandom} & 48'h00FF_FFFF_FFFF),
              48'({$urandom, $urandom} & 48'h0000_FFFF_FFFF));
      random_pairs(390);
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/mipd_pkg.sv
rtl/core/mipd_front.sv
rtl/core/mipd_fifo.sv
rtl/core/mipd_axis.sv
rtl/core/mipd_isqrt.sv
rtl/core/mipd_back.sv
rtl/core/min_image_pair_distance.sv
sim/mipd_checker.sv
sim/min_image_pair_distance_test.sv
